/* hdl/cac_pkg.sv */
// Shared types, constants and helpers of the chromatic aberration correction unit.
`timescale 1ns / 1ps
package cac_pkg;

	localparam int CH_W    = 14;
	localparam int WIN     = 7;
	localparam int LINES   = 6;
	localparam int GRAD_W  = 18;
	localparam int DIFF_W  = 15;
	localparam logic [CH_W-1:0] CH_MAX = 14'h3fff;

	// Configuration register indexes
	localparam logic [2:0] CFG_ENABLE = 3'd0;
	localparam logic [2:0] CFG_WIDTH  = 3'd1;
	localparam logic [2:0] CFG_HEIGHT = 3'd2;
	localparam logic [2:0] CFG_TRANS  = 3'd3;
	localparam logic [2:0] CFG_EDGE   = 3'd4;

	// Channel selects
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// Pixel with red in the top bits, blue in the bottom bits
	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} px_t;

	typedef logic signed [GRAD_W-1:0] grad_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef grad_t [4:0]        gch_t;
	typedef gch_t [2:0]         gset_t;
	typedef px_t [WIN-1:0]      line_t;
	typedef diff_t [WIN-1:0]    dline_t;
	typedef px_t [LINES-1:0]    lsw_t;

	// Thresholds handed to the line correction
	typedef struct packed {
		logic [15:0] trans_thr;
		logic [15:0] edge_thr;
	} thr_t;

	function automatic diff_t ch_diff(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
		ch_diff = $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	function automatic logic [CH_W-1:0] clip14(input logic signed [15:0] v);
		if (v < 0)
			clip14 = '0;
		else if (v > $signed({2'b00, CH_MAX}))
			clip14 = CH_MAX;
		else
			clip14 = v[CH_W-1:0];
	endfunction

endpackage

/* hdl/cac_in_if.sv */
// Input pixel stream channel.
`timescale 1ns / 1ps
interface cac_in_if;
	import cac_pkg::*;
	logic            valid;
	logic            ready;
	logic            func;
	logic [CH_W-1:0] in_red;
	logic [CH_W-1:0] in_green;
	logic [CH_W-1:0] in_blue;
	modport source (output valid, func, in_red, in_green, in_blue, input ready);
	modport sink (input valid, func, in_red, in_green, in_blue, output ready);
endinterface

/* hdl/cac_out_if.sv */
// Output pixel stream channel.
`timescale 1ns / 1ps
interface cac_out_if;
	import cac_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;
	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

/* hdl/cac_line_fix.sv */
// Color difference clamp along one seven pixel line of the window.
`timescale 1ns / 1ps
module cac_line_fix (
	input  cac_pkg::gset_t  grad,
	input  cac_pkg::line_t  pix,
	input  cac_pkg::dline_t bg,
	input  cac_pkg::dline_t rg,
	input  cac_pkg::thr_t   thr,
	output cac_pkg::line_t  fixed
);
	import cac_pkg::*;

	grad_t       tt, te, gc;
	logic        pos, act;
	logic [4:0]  flat;
	logic [2:0]  lo_end, hi_end;
	diff_t       b_hi, b_lo, r_hi, r_lo;

	assign tt  = $signed({2'b00, thr.trans_thr});
	assign te  = $signed({2'b00, thr.edge_thr});
	assign gc  = grad[CH_GREEN][2];
	assign pos = gc > tt;
	assign act = pos || (gc < -tt);

	// Flat test of every gradient position over all three channels
	always_comb begin
		for (int k = 0; k < 5; k++) begin
			flat[k] = 1'b1;
			for (int c = 0; c < 3; c++) begin
				if (pos ? !(grad[c][k] < te) : !(grad[c][k] > -te))
					flat[k] = 1'b0;
			end
		end
	end

	// Transient ends
	assign lo_end = flat[1] ? 3'd2 : (flat[0] ? 3'd1 : 3'd0);
	assign hi_end = flat[3] ? 3'd4 : (flat[4] ? 3'd5 : 3'd6);

	// Difference range at the ends
	always_comb begin
		b_hi = (bg[lo_end] > bg[hi_end]) ? bg[lo_end] : bg[hi_end];
		b_lo = (bg[lo_end] < bg[hi_end]) ? bg[lo_end] : bg[hi_end];
		r_hi = (rg[lo_end] > rg[hi_end]) ? rg[lo_end] : rg[hi_end];
		r_lo = (rg[lo_end] < rg[hi_end]) ? rg[lo_end] : rg[hi_end];
	end

	// Clamp pixels strictly between the ends
	always_comb begin
		logic signed [15:0] gs;
		fixed = pix;
		for (int k = 1; k < 6; k++) begin
			gs = $signed({2'b00, pix[k].g});
			if (act && (3'(k) > lo_end) && (3'(k) < hi_end)) begin
				if (bg[k] > b_hi)
					fixed[k].b = clip14(gs + {b_hi[DIFF_W-1], b_hi});
				else if (bg[k] < b_lo)
					fixed[k].b = clip14(gs + {b_lo[DIFF_W-1], b_lo});
				if (rg[k] > r_hi)
					fixed[k].r = clip14(gs + {r_hi[DIFF_W-1], r_hi});
				else if (rg[k] < r_lo)
					fixed[k].r = clip14(gs + {r_lo[DIFF_W-1], r_lo});
			end
		end
	end

endmodule

/* hdl/chromatic_aberration_correct_unit.sv */
// Top level of the chromatic aberration correction unit.
//
//  channel   dir  handshake      payload
//  pix_in    in   valid/ready    func, in_red, in_green, in_blue
//  pix_out   out  valid/ready    out_red, out_green, out_blue
//  cfg       in   cfg_we         cfg_index (3), cfg_wdata (16)
//
// One item per clock while ready is high: the 7x7 window, its shift, line store load and the
// correction of the middle row and column form one registered loop.
// After reset all MAX_LINE_WIDTH line store words are cleared, with ready low.
// A write of frame_width re-derives the drain position in the divider, with ready low.
// An item whose line store word is not the one fetched last cycle waits while its own
// word is fetched (first pixel of a new frame after drain, height or width change).
// One output register; input is taken while the held result is transferred.
`timescale 1ns / 1ps
module chromatic_aberration_correct_unit #(
	parameter int MAX_LINE_WIDTH = 8192
) (
	input  logic         clk,
	input  logic         arst_n,
	cac_in_if.sink       pix_in,
	cac_out_if.source    pix_out,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_wdata
);
	import cac_pkg::*;

	localparam int AW = $clog2(MAX_LINE_WIDTH);

	// Configuration
	logic        enable_q;
	logic [12:0] width_q, height_q;
	logic [15:0] trans_q, edge_q;

	// Position and drain state
	logic [12:0] row_q, col_q, row_n, col_n;
	logic [15:0] dcnt_q, dcnt_n;
	logic [2:0]  drow_q, drow_n;
	logic [12:0] dcol_q, dcol_n;

	// Window and line store
	px_t         win_q [WIN][WIN];
	px_t         sh    [WIN][WIN];
	px_t         win_n [WIN][WIN];
	lsw_t        line_mem [MAX_LINE_WIDTH];
	lsw_t        rd_q, byp_data_q, ld;
	logic        byp_q, rd_ok_q;
	logic [AW-1:0] rd_addr_q, raddr;
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	lsw_t        mem_wdata;
	logic        clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// Drain position divider
	logic        div_busy_q;
	logic [4:0]  div_cnt_q;
	logic [15:0] div_num_q, div_quo_q;
	logic [13:0] div_rem_q;
	logic [14:0] div_try;

	// Output register
	logic        out_valid_q;
	px_t         out_pix_q;

	// Item decode
	logic        acc, done, need_mem, emit;
	logic [12:0] row_e, col_e;
	logic [AW-1:0] need_addr;
	px_t         pix, res, pix_res, drain_res;
	logic        corr, pix_emit, drain_emit;
	logic [16:0] dlimit;

	// Correction
	gset_t       eh, ev;
	line_t       hline, hfix, vline, vfix;
	dline_t      bgh, rgh, bgv, rgv;
	thr_t        thr;

	function automatic logic [CH_W-1:0] chan(input px_t p, input logic [1:0] c);
		case (c)
			CH_RED:   chan = p.r;
			CH_GREEN: chan = p.g;
			default:  chan = p.b;
		endcase
	endfunction

	function automatic logic [GRAD_W-1:0] tri_sum(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b, input logic [CH_W-1:0] c);
		tri_sum = {4'b0, a} + {3'b0, b, 1'b0} + {4'b0, c};
	endfunction

	assign done  = row_q >= height_q;
	assign row_e = done ? '0 : row_q;
	assign col_e = done ? '0 : col_q;
	assign pix   = '{r: pix_in.in_red, g: pix_in.in_green, b: pix_in.in_blue};
	assign ld    = byp_q ? byp_data_q : rd_q;
	assign thr   = '{trans_thr: trans_q, edge_thr: edge_q};

	// Handshake: line store word must be the fetched one
	assign need_mem  = enable_q && (!pix_in.func || done);
	assign need_addr = pix_in.func ? dcol_q[AW-1:0] : col_e[AW-1:0];
	assign pix_in.ready = !clr_busy_q && !div_busy_q && (!out_valid_q || pix_out.ready) &&
		(!need_mem || (rd_ok_q && rd_addr_q == need_addr));
	assign acc = pix_in.valid && pix_in.ready;

	// Window shift and load
	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			for (int j = 0; j < WIN - 1; j++)
				sh[i][j] = win_q[i][j + 1];
			sh[i][WIN - 1] = (i < LINES) ? ld[i] : pix;
		end
	end

	// Gradients and color differences on the middle row and column
	always_comb begin
		for (int i = 0; i < 5; i++) begin
			for (int c = 0; c < 3; c++) begin
				eh[c][i] = $signed(tri_sum(chan(sh[2][i], 2'(c)), chan(sh[3][i], 2'(c)),
						chan(sh[4][i], 2'(c))) - tri_sum(chan(sh[2][i + 2], 2'(c)),
						chan(sh[3][i + 2], 2'(c)), chan(sh[4][i + 2], 2'(c))));
				ev[c][i] = $signed(tri_sum(chan(sh[i][2], 2'(c)), chan(sh[i][3], 2'(c)),
						chan(sh[i][4], 2'(c))) - tri_sum(chan(sh[i + 2][2], 2'(c)),
						chan(sh[i + 2][3], 2'(c)), chan(sh[i + 2][4], 2'(c))));
			end
		end
		for (int k = 0; k < WIN; k++) begin
			hline[k] = sh[3][k];
			bgh[k]   = ch_diff(sh[3][k].b, sh[3][k].g);
			rgh[k]   = ch_diff(sh[3][k].r, sh[3][k].g);
			bgv[k]   = ch_diff(sh[k][3].b, sh[k][3].g);
			rgv[k]   = ch_diff(sh[k][3].r, sh[k][3].g);
		end
	end

	cac_line_fix u_fix_h (
		.grad  (eh),
		.pix   (hline),
		.bg    (bgh),
		.rg    (rgh),
		.thr   (thr),
		.fixed (hfix)
	);

	// Vertical pass sees the center after the horizontal pass
	always_comb begin
		for (int k = 0; k < WIN; k++)
			vline[k] = (k == 3) ? hfix[3] : sh[k][3];
	end

	cac_line_fix u_fix_v (
		.grad  (ev),
		.pix   (vline),
		.bg    (bgv),
		.rg    (rgv),
		.thr   (thr),
		.fixed (vfix)
	);

	// Next window and pixel result
	assign corr     = (row_e > 13'd5) && (col_e > 13'd5);
	assign pix_emit = (row_e > 13'd5) || ((row_e == 13'd5) && (col_e > 13'd2));
	always_comb begin
		for (int i = 0; i < WIN; i++)
			for (int j = 0; j < WIN; j++)
				win_n[i][j] = sh[i][j];
		if (corr) begin
			for (int j = 1; j < WIN - 1; j++) begin
				win_n[3][j] = hfix[j];
				win_n[j][3] = vfix[j];
			end
		end
		pix_res = win_n[1][3];
	end

	// Drain result
	assign dlimit     = {2'b0, width_q, 2'b0} + {4'b0, width_q} + 17'd3;
	assign drain_emit = enable_q && done && ({1'b0, dcnt_q} < dlimit);
	always_comb begin
		logic [2:0]  rsel, wrow, cidx;
		logic [13:0] cpos;
		rsel = (drow_q > 3'd4) ? 3'd0 : drow_q + 3'd1;
		wrow = (drow_q > 3'd4) ? 3'd6 : drow_q + 3'd2;
		cpos = {1'b0, dcol_q} + 14'd7 - {1'b0, width_q};
		cidx = (cpos[2:0] == 3'd0) ? 3'd1 : cpos[2:0];
		if (dcnt_q < 16'd3)
			drain_res = win_q[1][3'd4 + {1'b0, dcnt_q[1:0]}];
		else if (({1'b0, dcol_q} + 14'd6) < {1'b0, width_q})
			drain_res = ld[rsel];
		else
			drain_res = win_q[wrow][cidx];
	end

	assign emit = pix_in.func ? drain_emit : (!enable_q || pix_emit);
	assign res  = pix_in.func ? drain_res : (enable_q ? pix_res : pix);

	// Next position and drain counters
	always_comb begin
		row_n  = row_q;
		col_n  = col_q;
		dcnt_n = dcnt_q;
		drow_n = drow_q;
		dcol_n = dcol_q;
		if (acc && !pix_in.func) begin
			if (done) begin
				dcnt_n = '0;
				drow_n = '0;
				dcol_n = '0;
			end
			if ({1'b0, col_e} + 14'd1 >= {1'b0, width_q}) begin
				col_n = '0;
				row_n = row_e + 13'd1;
			end else begin
				col_n = col_e + 13'd1;
				row_n = row_e;
			end
		end else if (acc && drain_emit) begin
			dcnt_n = dcnt_q + 16'd1;
			if (dcnt_q >= 16'd3) begin
				if ({1'b0, dcol_q} + 14'd1 >= {1'b0, width_q}) begin
					dcol_n = '0;
					drow_n = drow_q + 3'd1;
				end else begin
					dcol_n = dcol_q + 13'd1;
				end
			end
		end else if (div_busy_q && div_cnt_q == 5'd16) begin
			dcol_n = div_rem_q[12:0];
			drow_n = (div_quo_q > 16'd5) ? 3'd5 : div_quo_q[2:0];
		end
	end

	// Line store write port and prefetch address; a waiting item fetches its own word
	assign raddr = (pix_in.valid && !acc) ? need_addr :
		((row_n >= height_q) ? dcol_n[AW-1:0] : col_n[AW-1:0]);
	always_comb begin
		logic early;
		logic [13:0] wa;
		early = (row_e <= 13'd5) || ((row_e == 13'd6) && (col_e < 13'd6));
		wa = ((col_e >= 13'd6) ? {1'b0, col_e} : {1'b0, col_e} + {1'b0, width_q}) - 14'd6;
		mem_we    = clr_busy_q || (acc && !pix_in.func && enable_q);
		mem_waddr = early ? col_e[AW-1:0] : wa[AW-1:0];
		for (int i = 0; i < LINES; i++)
			mem_wdata[i] = early ? sh[i + 1][WIN - 1] : sh[i + 1][0];
		if (clr_busy_q) begin
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end
	end

	// Line store memory
	always_ff @(posedge clk) begin
		if (mem_we)
			line_mem[mem_waddr] <= mem_wdata;
		rd_q       <= line_mem[raddr];
		byp_data_q <= mem_wdata;
	end

	// Clearing pass, fetch tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			rd_ok_q    <= 1'b0;
			rd_addr_q  <= '0;
			byp_q      <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(MAX_LINE_WIDTH - 1))
					clr_busy_q <= 1'b0;
			end
			rd_ok_q   <= !clr_busy_q;
			rd_addr_q <= raddr;
			byp_q     <= mem_we && (mem_waddr == raddr);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			width_q  <= 13'd1920;
			height_q <= 13'd1080;
			trans_q  <= 16'd256;
			edge_q   <= 16'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE: enable_q <= cfg_wdata[0];
				CFG_WIDTH:  width_q  <= cfg_wdata[12:0];
				CFG_HEIGHT: height_q <= cfg_wdata[12:0];
				CFG_TRANS:  trans_q  <= cfg_wdata;
				CFG_EDGE:   edge_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Drain position divider: (drain_count - 3) / frame_width, one bit a cycle
	assign div_try = {div_rem_q, div_num_q[15]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
			div_num_q  <= '0;
			div_quo_q  <= '0;
			div_rem_q  <= '0;
		end else if (cfg_we && cfg_index == CFG_WIDTH) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= '0;
			div_num_q  <= (dcnt_q >= 16'd3) ? dcnt_q - 16'd3 : '0;
			div_quo_q  <= '0;
			div_rem_q  <= '0;
		end else if (div_busy_q) begin
			if (div_cnt_q == 5'd16) begin
				div_busy_q <= 1'b0;
			end else begin
				div_cnt_q <= div_cnt_q + 5'd1;
				div_num_q <= {div_num_q[14:0], 1'b0};
				if (div_try >= {2'b0, width_q}) begin
					div_rem_q <= 14'(div_try - {2'b0, width_q});
					div_quo_q <= {div_quo_q[14:0], 1'b1};
				end else begin
					div_rem_q <= div_try[13:0];
					div_quo_q <= {div_quo_q[14:0], 1'b0};
				end
			end
		end
	end

	// Counters and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			dcnt_q <= '0;
			drow_q <= '0;
			dcol_q <= '0;
			for (int i = 0; i < WIN; i++)
				for (int j = 0; j < WIN; j++)
					win_q[i][j] <= '0;
		end else begin
			row_q  <= row_n;
			col_q  <= col_n;
			dcnt_q <= dcnt_n;
			drow_q <= drow_n;
			dcol_q <= dcol_n;
			if (acc && !pix_in.func && enable_q)
				win_q <= win_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && emit) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && emit)
			out_pix_q <= res;
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.out_red   = out_pix_q.r;
	assign pix_out.out_green = out_pix_q.g;
	assign pix_out.out_blue  = out_pix_q.b;

	// Checks
	a_clr_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !pix_in.ready) else $error("item taken during line store clear");
	a_div_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q |-> !acc) else $error("item taken while drain position is derived");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (!out_valid_q || pix_out.ready)) else $error("held result overwritten");
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !pix_in.func && !enable_q) |=> out_valid_q)
		else $error("pass-through pixel lost");
	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && pix_in.func && !done) |=> !out_valid_q)
		else $error("drain before frame end produced a result");

endmodule
